// ===== hdl/wswr_pkg.sv =====
// Shared types and constants for the weighted sampler without replacement.
`default_nettype none

package wswr_pkg;

  // Default sizing of the sampler
  localparam int CAPACITY_DEF      = 1024;
  localparam int WEIGHT_BITS_DEF   = 32;
  localparam int FRACTION_BITS_DEF = 24;

  // Fixed widths of the word fields
  localparam int KIND_W   = 2;
  localparam int EDGE_W   = 32;
  localparam int COUNT_W  = 16;
  localparam int RAND_W   = 24;
  localparam int INDEX_W  = 10;

  // Item kinds
  localparam logic [KIND_W-1:0] KIND_LOAD  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd1;
  localparam logic [KIND_W-1:0] KIND_DRAW  = 2'd2;

  // Result status codes
  localparam logic STATUS_OK    = 1'b0;
  localparam logic STATUS_EMPTY = 1'b1;

  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [EDGE_W-1:0]  edge_weight;
    logic               new_set;
    logic [COUNT_W-1:0] sample_count;
    logic [RAND_W-1:0]  rand_fraction;
  } in_word_t;

  typedef struct packed {
    logic [INDEX_W-1:0] chosen_index;
    logic               status;
  } out_word_t;

endpackage

`default_nettype wire

// ===== hdl/wswr_node_mem.sv =====
// Sum-tree node memory: one write port, two registered read ports.
`default_nettype none

module wswr_node_mem #(
  parameter int ADDR_W = 11,
  parameter int DATA_W = 95
) (
  input  wire logic              clk,
  input  wire logic [ADDR_W-1:0] ra_addr,
  input  wire logic [ADDR_W-1:0] rb_addr,
  input  wire logic              we,
  input  wire logic [ADDR_W-1:0] wa,
  input  wire logic [DATA_W-1:0] wd,
  output      logic [DATA_W-1:0] ra_data,
  output      logic [DATA_W-1:0] rb_data
);

  logic [DATA_W-1:0] node_mem_r [2**ADDR_W];
  logic [DATA_W-1:0] ra_data_r;
  logic [DATA_W-1:0] rb_data_r;

  always_ff @(posedge clk) begin
    if (we) begin
      node_mem_r[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    ra_data_r <= node_mem_r[ra_addr];
    rb_data_r <= node_mem_r[rb_addr];
  end

  assign ra_data = ra_data_r;
  assign rb_data = rb_data_r;

endmodule

`default_nettype wire

// ===== hdl/wswr_scale.sv =====
// Query scaler: floor(r * total / 2^FRAC_W) in two partial products.
`default_nettype none

module wswr_scale #(
  parameter int FRAC_W = 24,
  parameter int SUM_W  = 42
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [FRAC_W-1:0] r,
  input  wire logic [SUM_W-1:0]  total,
  output      logic              done,
  output      logic [SUM_W-1:0]  q
);

  localparam int LO_W = (SUM_W + 1) / 2;
  localparam int HI_W = SUM_W - LO_W;
  localparam int P_W  = FRAC_W + SUM_W;

  logic [FRAC_W-1:0]      r_r;
  logic [HI_W-1:0]        hi_r;
  logic [FRAC_W+LO_W-1:0] p_lo_r;
  logic [FRAC_W+HI_W-1:0] p_hi_r;
  logic [1:0]             stg_r;
  logic [P_W-1:0]         prod;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_r <= '0;
    end else begin
      stg_r <= {stg_r[0], start};
    end
  end

  // low partial product on start, high one in the next cycle
  always_ff @(posedge clk) begin
    if (start) begin
      r_r    <= r;
      hi_r   <= total[SUM_W-1:LO_W];
      p_lo_r <= (FRAC_W+LO_W)'(r) * (FRAC_W+LO_W)'(total[LO_W-1:0]);
    end
    p_hi_r <= (FRAC_W+HI_W)'(r_r) * (FRAC_W+HI_W)'(hi_r);
  end

  assign prod = (P_W'(p_hi_r) << LO_W) + P_W'(p_lo_r);
  assign q    = prod[FRAC_W +: SUM_W];
  assign done = stg_r[1];

endmodule

`default_nettype wire

// ===== hdl/weighted_sample_without_replacement_top.sv =====
// Top level of the weighted sampler without replacement over a sum tree.
`default_nettype none

// Weighted sampler without replacement. Load words append a Q16.16 weight to
// the set (new_set first discards the old set; loads past CAPACITY are
// dropped), a begin word opens a request for sample_count draws (capped at
// the loaded count), and each draw word returns one result word: a leaf
// index with status 0, or index 0 with status 1 once the request has no
// draws left. Any load ends the active request. When the request covers the
// whole set, draws return 0,1,2,... in order. Otherwise a draw scales
// rand_fraction by the remaining weight and walks a padded power-of-two sum
// tree held in one node memory (sum, removed sum and removed count per
// node), then walks back up to remove the chosen leaf. With L = clog2(CAPACITY)
// tree levels (10 by default), a tree draw goes through accept, root read,
// the query scaler, one step per level down, one read-modify-write per node
// on the way up and a hand-off of the word to the output register; a load
// does the read-modify-write walk to the root; a begin that samples a subset
// clears the removal fields with a pass over all 2^(L+1) nodes, one node a
// cycle. One word is worked on at a time; a finished result waits in the
// output register while the next input word is taken.
module weighted_sample_without_replacement_top
  import wswr_pkg::*;
#(
  parameter int CAPACITY      = CAPACITY_DEF,
  parameter int WEIGHT_BITS   = WEIGHT_BITS_DEF,
  parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output      logic      in_stall,
  input  wire in_word_t  in_word,
  output      logic      out_valid,
  input  wire logic      out_stall,
  output      out_word_t out_word
);

  localparam int LEVELS = $clog2(CAPACITY);
  localparam int TL     = 1 << LEVELS;
  localparam int NODE_W = LEVELS + 1;
  localparam int CNT_W  = LEVELS + 1;
  localparam int SUM_W  = WEIGHT_BITS + LEVELS;
  localparam int WORD_W = 2 * SUM_W + CNT_W;

  localparam logic [CNT_W-1:0]  CAP_C   = CNT_W'(CAPACITY);
  localparam logic [CNT_W-1:0]  HALF0_C = CNT_W'(TL / 2);
  localparam logic [NODE_W-1:0] ROOT_C  = NODE_W'(1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_UP   = 8'b0000_0010,
    S_CLR  = 8'b0000_0100,
    S_CLRW = 8'b0000_1000,
    S_TOT  = 8'b0001_0000,
    S_MUL  = 8'b0010_0000,
    S_DESC = 8'b0100_0000,
    S_EMIT = 8'b1000_0000
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   loaded_r, loaded_nxt;
  logic               take_all_r, take_all_nxt;
  logic [CNT_W-1:0]   draws_r, draws_nxt;
  logic [CNT_W-1:0]   seq_r, seq_nxt;
  logic [NODE_W-1:0]  node_r, node_nxt;
  logic [CNT_W-1:0]   lo_r, lo_nxt;
  logic [CNT_W-1:0]   half_r, half_nxt;
  logic [SUM_W-1:0]   q_r, q_nxt;
  logic [SUM_W-1:0]   w_r, w_nxt;
  logic [CNT_W-1:0]   leaf_r, leaf_nxt;
  logic [CNT_W-1:0]   mask_r, mask_nxt;
  logic               remove_r, remove_nxt;
  logic [FRACTION_BITS-1:0] r_r, r_nxt;
  logic [SUM_W-1:0]   total_r, total_nxt;
  logic               start_r, start_nxt;
  logic [NODE_W-1:0]  clr_r, clr_nxt;
  logic [NODE_W-1:0]  clr_wa_r, clr_wa_nxt;
  out_word_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  // memory ports
  logic [NODE_W-1:0]  ra_addr, rb_addr, wa;
  logic               we;
  logic [WORD_W-1:0]  wd, rd_a, rd_b;

  // node word fields: {sum, removed sum, removed count}
  logic [SUM_W-1:0]   a_sum, a_rw;
  logic [CNT_W-1:0]   a_rc, b_rc;

  logic               sc_done;
  logic [SUM_W-1:0]   sc_q;

  // descent decision
  logic [CNT_W-1:0]   lcnt, rcnt, rlo;
  logic [SUM_W-1:0]   lrem;
  logic               go_left;
  logic [NODE_W-1:0]  child;
  logic [CNT_W-1:0]   lo_c;

  // ascent update
  logic               is_leaf;
  logic [SUM_W-1:0]   w_eff;
  logic               first;
  logic [CNT_W-1:0]   base;
  logic [WEIGHT_BITS-1:0] wt;

  assign a_sum = rd_a[WORD_W-1 -: SUM_W];
  assign a_rw  = rd_a[CNT_W +: SUM_W];
  assign a_rc  = rd_a[CNT_W-1:0];
  assign b_rc  = rd_b[CNT_W-1:0];

  // loaded leaves inside [lo, lo + span)
  function automatic logic [CNT_W-1:0] loaded_in(input logic [CNT_W-1:0] cnt,
                                                 input logic [CNT_W-1:0] lo,
                                                 input logic [CNT_W-1:0] span);
    logic [CNT_W-1:0] diff;
    diff = cnt - lo;
    if (cnt <= lo) begin
      loaded_in = '0;
    end else if (diff >= span) begin
      loaded_in = span;
    end else begin
      loaded_in = diff;
    end
  endfunction

  wswr_node_mem #(
    .ADDR_W (NODE_W),
    .DATA_W (WORD_W)
  ) u_mem (
    .clk     (clk),
    .ra_addr (ra_addr),
    .rb_addr (rb_addr),
    .we      (we),
    .wa      (wa),
    .wd      (wd),
    .ra_data (rd_a),
    .rb_data (rd_b)
  );

  wswr_scale #(
    .FRAC_W (FRACTION_BITS),
    .SUM_W  (SUM_W)
  ) u_scale (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start_r),
    .r     (r_r),
    .total (total_r),
    .done  (sc_done),
    .q     (sc_q)
  );

  // Descent: left child on port A, right child on port B. Take the left
  // child when the right side has nothing left, or when the left side has
  // a leaf and enough remaining weight to reach the query.
  assign rlo     = lo_r + half_r;
  assign lcnt    = loaded_in(loaded_r, lo_r, half_r) - a_rc;
  assign rcnt    = loaded_in(loaded_r, rlo, half_r) - b_rc;
  assign lrem    = a_sum - a_rw;
  assign go_left = (rcnt == '0) || ((lcnt != '0) && (lrem >= q_r));
  assign child   = {node_r[NODE_W-2:0], ~go_left};
  assign lo_c    = go_left ? lo_r : rlo;

  // Ascent: a leaf node supplies the weight to remove; a node that first
  // sees the newly loaded leaf starts its sum over.
  assign is_leaf = node_r[LEVELS];
  assign w_eff   = is_leaf ? a_sum : w_r;
  assign first   = ((leaf_r & mask_r) == '0);
  assign base    = in_word.new_set ? '0 : loaded_r;
  assign wt      = WEIGHT_BITS'(in_word.edge_weight);

  always_comb begin
    state_nxt     = state_r;
    loaded_nxt    = loaded_r;
    take_all_nxt  = take_all_r;
    draws_nxt     = draws_r;
    seq_nxt       = seq_r;
    node_nxt      = node_r;
    lo_nxt        = lo_r;
    half_nxt      = half_r;
    q_nxt         = q_r;
    w_nxt         = w_r;
    leaf_nxt      = leaf_r;
    mask_nxt      = mask_r;
    remove_nxt    = remove_r;
    r_nxt         = r_r;
    total_nxt     = total_r;
    start_nxt     = 1'b0;
    clr_nxt       = clr_r;
    clr_wa_nxt    = clr_wa_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r;
    out_word_nxt  = out_word_r;
    ra_addr       = node_r;
    rb_addr       = node_r;
    we            = 1'b0;
    wa            = node_r;
    wd            = rd_a;

    // drop the result word once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          case (in_word.kind)
            KIND_LOAD: begin
              take_all_nxt = 1'b0;
              draws_nxt    = '0;
              seq_nxt      = '0;
              loaded_nxt   = base;
              if (base < CAP_C) begin
                loaded_nxt = base + CNT_W'(1);
                leaf_nxt   = base;
                w_nxt      = SUM_W'(wt);
                node_nxt   = {1'b1, base[LEVELS-1:0]};
                ra_addr    = {1'b1, base[LEVELS-1:0]};
                mask_nxt   = '0;
                remove_nxt = 1'b0;
                state_nxt  = S_UP;
              end
            end
            KIND_BEGIN: begin
              seq_nxt = '0;
              if (32'(in_word.sample_count) >= 32'(loaded_r)) begin
                take_all_nxt = 1'b1;
                draws_nxt    = loaded_r;
              end else begin
                take_all_nxt = 1'b0;
                draws_nxt    = CNT_W'(in_word.sample_count);
                clr_nxt      = '0;
                state_nxt    = S_CLR;
              end
            end
            KIND_DRAW: begin
              if (draws_r == '0) begin
                res_nxt.chosen_index = '0;
                res_nxt.status       = STATUS_EMPTY;
                state_nxt            = S_EMIT;
              end else if (take_all_r) begin
                draws_nxt            = draws_r - CNT_W'(1);
                res_nxt.chosen_index = INDEX_W'(seq_r);
                res_nxt.status       = STATUS_OK;
                seq_nxt              = seq_r + CNT_W'(1);
                state_nxt            = S_EMIT;
              end else begin
                draws_nxt = draws_r - CNT_W'(1);
                r_nxt     = FRACTION_BITS'(in_word.rand_fraction);
                ra_addr   = ROOT_C;
                state_nxt = S_TOT;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_UP: begin
        we = 1'b1;
        wa = node_r;
        if (remove_r) begin
          w_nxt = w_eff;
          wd    = {a_sum, a_rw + w_eff, a_rc + CNT_W'(1)};
        end else begin
          wd    = {(first ? w_r : a_sum + w_r), a_rw, a_rc};
        end
        mask_nxt = {mask_r[CNT_W-2:0], 1'b1};
        if (node_r == ROOT_C) begin
          state_nxt = remove_r ? S_EMIT : S_IDLE;
        end else begin
          node_nxt = node_r >> 1;
          ra_addr  = node_r >> 1;
        end
      end

      S_CLR: begin
        // read one node a cycle, write it back in the following cycle with removals zeroed
        ra_addr    = clr_r;
        clr_wa_nxt = clr_r;
        clr_nxt    = clr_r + NODE_W'(1);
        if (clr_r != '0) begin
          we = 1'b1;
          wa = clr_wa_r;
          wd = {a_sum, {SUM_W{1'b0}}, {CNT_W{1'b0}}};
        end
        if (clr_r == '1) begin
          state_nxt = S_CLRW;
        end
      end

      S_CLRW: begin
        we        = 1'b1;
        wa        = clr_wa_r;
        wd        = {a_sum, {SUM_W{1'b0}}, {CNT_W{1'b0}}};
        state_nxt = S_IDLE;
      end

      S_TOT: begin
        total_nxt = a_sum - a_rw;
        start_nxt = 1'b1;
        state_nxt = S_MUL;
      end

      S_MUL: begin
        if (sc_done) begin
          q_nxt     = sc_q;
          node_nxt  = ROOT_C;
          lo_nxt    = '0;
          half_nxt  = HALF0_C;
          ra_addr   = NODE_W'(2);
          rb_addr   = NODE_W'(3);
          state_nxt = S_DESC;
        end
      end

      S_DESC: begin
        node_nxt = child;
        lo_nxt   = lo_c;
        if (!go_left) begin
          q_nxt = (q_r > lrem) ? q_r - lrem : '0;
        end
        if (half_r == CNT_W'(1)) begin
          // reached a leaf: report it, then remove it on the way up
          res_nxt.chosen_index = INDEX_W'(lo_c);
          res_nxt.status       = STATUS_OK;
          ra_addr              = child;
          remove_nxt           = 1'b1;
          state_nxt            = S_UP;
        end else begin
          half_nxt = half_r >> 1;
          ra_addr  = {child[NODE_W-2:0], 1'b0};
          rb_addr  = {child[NODE_W-2:0], 1'b1};
        end
      end

      S_EMIT: begin
        // hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_word_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      loaded_r    <= '0;
      take_all_r  <= 1'b0;
      draws_r     <= '0;
      seq_r       <= '0;
      start_r     <= 1'b0;
      remove_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      loaded_r    <= loaded_nxt;
      take_all_r  <= take_all_nxt;
      draws_r     <= draws_nxt;
      seq_r       <= seq_nxt;
      start_r     <= start_nxt;
      remove_r    <= remove_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    node_r     <= node_nxt;
    lo_r       <= lo_nxt;
    half_r     <= half_nxt;
    q_r        <= q_nxt;
    w_r        <= w_nxt;
    leaf_r     <= leaf_nxt;
    mask_r     <= mask_nxt;
    r_r        <= r_nxt;
    total_r    <= total_nxt;
    clr_r      <= clr_nxt;
    clr_wa_r   <= clr_wa_nxt;
    res_r      <= res_nxt;
    out_word_r <= out_word_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

// ===== hdl/wswr_checker.sv =====
// Port-level checker for the weighted sampler, bound to the top level.
`default_nettype none

module wswr_checker
  import wswr_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_word_t  in_word,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_word_t out_word
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("stalled result word changed");

  // the input always stalls in the cycle after a draw is taken
  a_draw_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && (in_word.kind == KIND_DRAW) |=> in_stall)
    else $error("input taken right after a draw");

  // an exhausted request answers index zero
  a_empty_idx: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_word.status == STATUS_EMPTY) |-> (out_word.chosen_index == '0))
    else $error("exhausted draw with nonzero index");

  // no result word right out of reset
  a_rst_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind weighted_sample_without_replacement_top wswr_checker u_wswr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

`default_nettype wire
